FILE: rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds the microcode word layout, step codes and screen geometry; no dependencies.
package tcw_pkg;

    // Screen geometry
    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int NCELLS = COLS * ROWS;
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int CUR_W  = $clog2(NCELLS + 1);
    localparam int COL_W  = $clog2(COLS);

    // Item field widths
    localparam int REQ_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int CURSOR_W   = 11;
    localparam int ATTR_W     = 8;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;
    localparam int M_FIELDS_W = CURSOR_W + CHAR_W + ATTR_W;

    localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 8'h0f;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [REQ_W-1:0] {
        REQ_PRINT,
        REQ_CLEAR,
        REQ_READ,
        REQ_NONE
    } req_t;

    // Microprogram addresses
    typedef enum logic [3:0] {
        ST_INIT,
        ST_RSTCLR,
        ST_IDLE,
        ST_PUT,
        ST_RDOUT,
        ST_NL,
        ST_EMIT,
        ST_CLR,
        ST_SCR_LD,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_SCR_LR,
        ST_SCR_ZR,
        ST_PRN
    } step_t;

    typedef enum logic [2:0] {
        CNT_HOLD,
        CNT_ZERO,
        CNT_INC,
        CNT_COLS,
        CNT_LASTROW
    } cnt_op_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_INC,
        CUR_ZERO,
        CUR_SUBCOLS
    } cur_op_t;

    typedef enum logic [1:0] {
        WA_CUR,
        WA_CNT,
        WA_CNT_UP
    } wa_sel_t;

    typedef enum logic {
        RA_IN,
        RA_CNT
    } ra_sel_t;

    typedef enum logic [1:0] {
        WD_ZERO,
        WD_PUT,
        WD_COPY
    } wd_sel_t;

    typedef enum logic [2:0] {
        C_TRUE,
        C_CNT_LAST,
        C_COL_LAST,
        C_IS_NL,
        C_DISPATCH
    } cond_t;

    // One control word
    typedef struct packed {
        cnt_op_t cnt_op;
        cur_op_t cur_op;
        wa_sel_t wa_sel;
        ra_sel_t ra_sel;
        logic    rd_en;
        logic    we_char;
        logic    we_attr;
        wd_sel_t wd_sel;
        logic    take_in;
        logic    emit;
        logic    out_rd;
        cond_t   cond;
        step_t   tgt_t;
        step_t   tgt_f;
    } cw_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic hold;
        logic cnt_last;
        logic col_last;
        logic is_nl;
        req_t req;
        logic at_end;
        logic in_nl;
    } stat_t;

endpackage

FILE: rtl/tcw_ucode_rom.sv
// Control store of the text console writer: one control word per step.
// Depends on tcw_pkg.
module tcw_ucode_rom
    import tcw_pkg::*;
(
    input  step_t step,
    output cw_t   cw
);

    always_comb begin
        cw       = '0;
        cw.tgt_t = ST_IDLE;
        cw.tgt_f = ST_IDLE;
        unique case (step)
            ST_INIT: begin
                cw.cnt_op = CNT_ZERO;
                cw.tgt_t  = ST_RSTCLR;
            end
            ST_RSTCLR: begin
                // power-up sweep: both bytes to zero
                cw.wa_sel  = WA_CNT;
                cw.we_char = 1'b1;
                cw.we_attr = 1'b1;
                cw.wd_sel  = WD_ZERO;
                cw.cnt_op  = CNT_INC;
                cw.cond    = C_CNT_LAST;
                cw.tgt_t   = ST_IDLE;
                cw.tgt_f   = ST_RSTCLR;
            end
            ST_IDLE: begin
                cw.take_in = 1'b1;
                cw.rd_en   = 1'b1;
                cw.ra_sel  = RA_IN;
                cw.cnt_op  = CNT_ZERO;
                cw.cond    = C_DISPATCH;
            end
            ST_PUT: begin
                cw.wa_sel  = WA_CUR;
                cw.we_char = 1'b1;
                cw.we_attr = 1'b1;
                cw.wd_sel  = WD_PUT;
                cw.cur_op  = CUR_INC;
                cw.emit    = 1'b1;
            end
            ST_RDOUT: begin
                cw.emit   = 1'b1;
                cw.out_rd = 1'b1;
            end
            ST_NL: begin
                cw.wa_sel  = WA_CUR;
                cw.we_char = 1'b1;
                cw.wd_sel  = WD_ZERO;
                cw.cur_op  = CUR_INC;
                cw.cond    = C_COL_LAST;
                cw.tgt_t   = ST_EMIT;
                cw.tgt_f   = ST_NL;
            end
            ST_EMIT: begin
                cw.emit = 1'b1;
            end
            ST_CLR: begin
                cw.wa_sel  = WA_CNT;
                cw.we_char = 1'b1;
                cw.wd_sel  = WD_ZERO;
                cw.cnt_op  = CNT_INC;
                cw.cur_op  = CUR_ZERO;
                cw.cond    = C_CNT_LAST;
                cw.tgt_t   = ST_EMIT;
                cw.tgt_f   = ST_CLR;
            end
            ST_SCR_LD: begin
                cw.cnt_op = CNT_COLS;
                cw.tgt_t  = ST_SCR_RD;
            end
            ST_SCR_RD: begin
                cw.rd_en  = 1'b1;
                cw.ra_sel = RA_CNT;
                cw.tgt_t  = ST_SCR_WR;
            end
            ST_SCR_WR: begin
                // cell moves up one line
                cw.wa_sel  = WA_CNT_UP;
                cw.we_char = 1'b1;
                cw.we_attr = 1'b1;
                cw.wd_sel  = WD_COPY;
                cw.cnt_op  = CNT_INC;
                cw.cond    = C_CNT_LAST;
                cw.tgt_t   = ST_SCR_LR;
                cw.tgt_f   = ST_SCR_RD;
            end
            ST_SCR_LR: begin
                cw.cnt_op = CNT_LASTROW;
                cw.cur_op = CUR_SUBCOLS;
                cw.tgt_t  = ST_SCR_ZR;
            end
            ST_SCR_ZR: begin
                // last line: characters cleared, attributes kept
                cw.wa_sel  = WA_CNT;
                cw.we_char = 1'b1;
                cw.wd_sel  = WD_ZERO;
                cw.cnt_op  = CNT_INC;
                cw.cond    = C_CNT_LAST;
                cw.tgt_t   = ST_PRN;
                cw.tgt_f   = ST_SCR_ZR;
            end
            ST_PRN: begin
                cw.cond  = C_IS_NL;
                cw.tgt_t = ST_NL;
                cw.tgt_f = ST_PUT;
            end
            default: begin
                cw.tgt_t = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/tcw_seq.sv
// Step counter and branch logic of the text console writer microprogram.
// Depends on tcw_pkg.
module tcw_seq
    import tcw_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cw_t   cw,
    input  stat_t stat,
    output step_t step
);

    step_t step_reg;
    step_t step_next;
    step_t disp_tgt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_INIT;
        end else begin
            step_reg <= step_next;
        end
    end

    // Request dispatch out of idle
    always_comb begin
        unique case (stat.req)
            REQ_PRINT: begin
                if (stat.at_end) begin
                    disp_tgt = ST_SCR_LD;
                end else if (stat.in_nl) begin
                    disp_tgt = ST_NL;
                end else begin
                    disp_tgt = ST_PUT;
                end
            end
            REQ_CLEAR: disp_tgt = ST_CLR;
            REQ_READ:  disp_tgt = ST_RDOUT;
            default:   disp_tgt = ST_EMIT;
        endcase
    end

    always_comb begin
        if (stat.hold) begin
            step_next = step_reg;
        end else begin
            unique case (cw.cond)
                C_TRUE:     step_next = cw.tgt_t;
                C_CNT_LAST: step_next = stat.cnt_last ? cw.tgt_t : cw.tgt_f;
                C_COL_LAST: step_next = stat.col_last ? cw.tgt_t : cw.tgt_f;
                C_IS_NL:    step_next = stat.is_nl ? cw.tgt_t : cw.tgt_f;
                C_DISPATCH: step_next = disp_tgt;
                default:    step_next = ST_IDLE;
            endcase
        end
    end

    assign step = step_reg;

endmodule

FILE: rtl/tcw_cellmem.sv
// Character and attribute byte stores of the console, one write and one read port each.
// Read data is registered. Depends on tcw_pkg.
module tcw_cellmem
    import tcw_pkg::*;
(
    input  logic              aclk,
    input  logic              we_char,
    input  logic              we_attr,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CHAR_W-1:0] wchar,
    input  logic [ATTR_W-1:0] wattr,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CHAR_W-1:0] rchar,
    output logic [ATTR_W-1:0] rattr
);

    logic [CHAR_W-1:0] char_mem [NCELLS];
    logic [ATTR_W-1:0] attr_mem [NCELLS];
    logic [CHAR_W-1:0] rchar_reg;
    logic [ATTR_W-1:0] rattr_reg;

    always_ff @(posedge aclk) begin
        if (we_char) begin
            char_mem[waddr] <= wchar;
        end
        if (we_attr) begin
            attr_mem[waddr] <= wattr;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rchar_reg <= char_mem[raddr];
            rattr_reg <= attr_mem[raddr];
        end
    end

    assign rchar = rchar_reg;
    assign rattr = rattr_reg;

endmodule

FILE: rtl/text_console_writer.sv
// Text console writer top level: handshakes, cursor and counter datapath, output register.
// Depends on tcw_pkg, tcw_ucode_rom, tcw_seq and tcw_cellmem.
//
//  channel | ports             | payload
//  --------+-------------------+-----------------------------------------------
//  in      | s_tvalid/s_tready | s_tuser: req_type; s_tdata: char_code, cell_index
//  out     | m_tvalid/m_tready | m_tdata: cursor, cell_char, cell_attr
//
// A newline steps through the cells left on its line, and a clear sweeps every cell. A
// print with the cursor at screen end first scrolls: every cell below the first line
// moves up one line, then the characters of the last line are cleared.
// The cell store (one read and one write port) is swept one cell per step by the
// microprogram, with a scroll taking a read step and a write step per cell.
// After reset a clearing pass runs with s_tready low.
// A result waiting in the output register does not block the next accept; a
// stalled output only holds the step that wants to load a new result.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [REQ_W-1:0]     s_tuser,   // [1:0] req_type
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] char_code, [18:8] cell_index
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [10:0] cursor, [18:11] cell_char, [26:19] cell_attr
);

    step_t step;
    cw_t   cw;
    stat_t stat;

    // Latched request fields
    logic [CHAR_W-1:0] code_reg;
    logic [IDX_W-1:0]  idx_reg;

    // Sweep counter, cursor and its column
    logic [ADDR_W-1:0] cnt_reg,    cnt_next;
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg,    col_next;

    // Output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic              out_free;
    logic              hold;
    logic              adv;
    logic              accept;
    logic [CHAR_W-1:0] in_code;
    logic [IDX_W-1:0]  in_idx;

    // Memory port signals
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              rd_en;
    logic [CHAR_W-1:0] wchar;
    logic [ATTR_W-1:0] wattr;
    logic [CHAR_W-1:0] rchar;
    logic [ATTR_W-1:0] rattr;
    logic [CHAR_W-1:0] out_char;
    logic [ATTR_W-1:0] out_attr;

    tcw_ucode_rom u_rom (
        .step (step),
        .cw   (cw)
    );

    tcw_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cw      (cw),
        .stat    (stat),
        .step    (step)
    );

    tcw_cellmem u_mem (
        .aclk    (aclk),
        .we_char (cw.we_char && adv),
        .we_attr (cw.we_attr && adv),
        .waddr   (waddr),
        .wchar   (wchar),
        .wattr   (wattr),
        .re      (rd_en),
        .raddr   (raddr),
        .rchar   (rchar),
        .rattr   (rattr)
    );

    assign in_code  = s_tdata[CHAR_W-1:0];
    assign in_idx   = s_tdata[CHAR_W +: IDX_W];
    assign out_free = !m_tvalid_reg || m_tready;

    // A step stalls waiting for an input item or for room in the output register
    assign hold   = (cw.take_in && !s_tvalid) || (cw.emit && !out_free);
    assign adv    = !hold;
    assign accept = cw.take_in && s_tvalid;

    assign s_tready = cw.take_in;

    // Status for the sequencer
    assign stat.hold     = hold;
    assign stat.cnt_last = (cnt_reg == ADDR_W'(NCELLS - 1));
    assign stat.col_last = (col_reg == COL_W'(COLS - 1));
    assign stat.is_nl    = (code_reg == NEWLINE_CODE);
    assign stat.req      = req_t'(s_tuser);
    assign stat.at_end   = (cursor_reg == CUR_W'(NCELLS));
    assign stat.in_nl    = (in_code == NEWLINE_CODE);

    always_ff @(posedge aclk) begin
        if (accept) begin
            code_reg <= in_code;
            idx_reg  <= in_idx;
        end
    end

    // Sweep counter
    always_comb begin
        unique case (cw.cnt_op)
            CNT_HOLD:    cnt_next = cnt_reg;
            CNT_ZERO:    cnt_next = '0;
            CNT_INC:     cnt_next = cnt_reg + 1'b1;
            CNT_COLS:    cnt_next = ADDR_W'(COLS);
            CNT_LASTROW: cnt_next = ADDR_W'(NCELLS - COLS);
            default:     cnt_next = cnt_reg;
        endcase
    end

    // Cursor with its column tracked alongside, so no divide by COLS is needed
    always_comb begin
        unique case (cw.cur_op)
            CUR_HOLD: begin
                cursor_next = cursor_reg;
                col_next    = col_reg;
            end
            CUR_INC: begin
                cursor_next = cursor_reg + 1'b1;
                col_next    = (col_reg == COL_W'(COLS - 1)) ? '0 : col_reg + 1'b1;
            end
            CUR_ZERO: begin
                cursor_next = '0;
                col_next    = '0;
            end
            CUR_SUBCOLS: begin
                cursor_next = cursor_reg - CUR_W'(COLS);
                col_next    = col_reg;
            end
            default: begin
                cursor_next = cursor_reg;
                col_next    = col_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            cursor_reg <= '0;
            col_reg    <= '0;
        end else if (adv) begin
            cnt_reg    <= cnt_next;
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
        end
    end

    // Write address and data
    always_comb begin
        unique case (cw.wa_sel)
            WA_CUR:    waddr = ADDR_W'(cursor_reg);
            WA_CNT:    waddr = cnt_reg;
            WA_CNT_UP: waddr = cnt_reg - ADDR_W'(COLS);
            default:   waddr = cnt_reg;
        endcase
    end

    always_comb begin
        unique case (cw.wd_sel)
            WD_ZERO: begin
                wchar = '0;
                wattr = '0;
            end
            WD_PUT: begin
                wchar = code_reg;
                wattr = ATTR_DEFAULT;
            end
            WD_COPY: begin
                wchar = rchar;
                wattr = rattr;
            end
            default: begin
                wchar = '0;
                wattr = '0;
            end
        endcase
    end

    // Read address; a cell index past the screen never reaches the store
    always_comb begin
        unique case (cw.ra_sel)
            RA_IN: begin
                raddr = ADDR_W'(in_idx);
                rd_en = cw.rd_en && (32'(in_idx) < NCELLS);
            end
            RA_CNT: begin
                raddr = cnt_reg;
                rd_en = cw.rd_en;
            end
            default: begin
                raddr = cnt_reg;
                rd_en = 1'b0;
            end
        endcase
    end

    assign out_char = (cw.out_rd && (32'(idx_reg) < NCELLS)) ? rchar : '0;
    assign out_attr = (cw.out_rd && (32'(idx_reg) < NCELLS)) ? rattr : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cw.emit && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cw.emit && out_free) begin
            m_tdata_reg <= {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_attr, out_char,
                            CURSOR_W'(cursor_next)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
